[rtl/rounded_rect_alpha_compositor_macros.svh]
// ----------------------------------------------------------------------------
// Rounded rectangle alpha compositor - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_ALPHA_COMPOSITOR_MACROS_SVH
`define ROUNDED_RECT_ALPHA_COMPOSITOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define RRAC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rrac assertion failed");
// next-cycle implication
`define RRAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rrac assertion failed");
`else
`define RRAC_ASSERT_IMPL(label, ante, cons)
`define RRAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/rrac_pkg.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle alpha compositor - package
// Widths, register indexes, geometry helper and the divide by 255.
// ----------------------------------------------------------------------------
package rrac_pkg;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int RAD_W   = 12;
	localparam int COLOR_W = 24;
	localparam int ALPHA_W = 8;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 24;
	localparam int PROD_W  = 2 * CH_W;
	localparam int SQ_W    = 2 * RAD_W;

	localparam int unsigned COORD_LIMIT = 4096;
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

	typedef enum logic [IDX_W-1:0] {
		REG_RECT_X      = 3'd0,
		REG_RECT_Y      = 3'd1,
		REG_RECT_WIDTH  = 3'd2,
		REG_RECT_HEIGHT = 3'd3,
		REG_CORNER_RAD  = 3'd4,
		REG_FILL_COLOR  = 3'd5,
		REG_BLEND_ALPHA = 3'd6
	} cfg_reg_t;

	// result of testing one axis against the shape
	typedef struct packed {
		logic             in_span;
		logic             strip;
		logic [RAD_W-1:0] corner_off;
	} axis_t;

	// l is pixel minus edge, bit 12 set when negative
	function automatic axis_t axis_eval(logic [DIM_W-1:0] l, logic [DIM_W-1:0] len,
			logic [RAD_W-1:0] r);
		axis_t            res;
		logic [DIM_W-1:0] lu;
		logic [DIM_W-1:0] rr;
		logic [DIM_W-1:0] lenmr;
		logic [DIM_W-1:0] dlo;
		logic [DIM_W-1:0] dhi;
		logic             lo_ok;
		logic             hi_ok;
		lu     = {1'b0, l[COORD_W-1:0]};
		rr     = {1'b0, r};
		lenmr  = len - rr;
		dlo    = rr - lu;
		dhi    = lu - (lenmr - DIM_W'(1));
		lo_ok  = lu <= rr;
		hi_ok  = lu >= (lenmr - DIM_W'(1));
		res.in_span    = !l[DIM_W-1] && (lu < len);
		res.strip      = (lu >= rr) && (lu < lenmr);
		res.corner_off = (lo_ok && (!hi_ok || dlo <= dhi)) ? dlo[RAD_W-1:0] : dhi[RAD_W-1:0];
		return res;
	endfunction

	// exact floor(v / 255) for v up to 255 * 255
	function automatic logic [CH_W-1:0] div255(logic [PROD_W-1:0] v);
		logic [PROD_W:0] t;
		t = {1'b0, v} + {{(CH_W+1){1'b0}}, v[PROD_W-1:CH_W]} + (PROD_W+1)'(1);
		return t[PROD_W-1:CH_W];
	endfunction

endpackage

[rtl/rounded_rect_alpha_compositor.sv]
// ----------------------------------------------------------------------------
// Rounded rectangle alpha compositor - top level
// Tests each destination pixel against a rounded rectangle and blends the
// fill colour over it with the configured alpha.
//
// Usage
//   s_axis carries one pixel per item: its column, row and current colour.
//   m_axis returns one item for every pixel, in order: the resulting colour
//   in tdata and the covered flag in tuser.
//   Registers are written through cfg_wr_en / cfg_index / cfg_data while no
//   item is in flight; unknown indexes are ignored.
//   While the output is not stalled, one item per cycle is sustained. The
//   path is four register stages: offsets, corner distances and channel
//   products, squares and channel sums, coverage test and divide by 255
//   into the output register. Each stage takes a new item when it is empty
//   or its successor moves, so a stall on m_axis holds every item in place,
//   bubbles are squeezed out and s_axis_tready drops only when all four
//   stages are full.
//   Reset empties the pipeline and loads the registers with their defaults:
//   all zero except the alpha, which is fully opaque.
// ----------------------------------------------------------------------------
`include "rounded_rect_alpha_compositor_macros.svh"

module rounded_rect_alpha_compositor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [rrac_pkg::IDX_W-1:0]             cfg_index,
	input  logic [rrac_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// pixel_x 11:0, pixel_y 23:12, dest_color 47:24
	input  logic [2*rrac_pkg::COORD_W+rrac_pkg::COLOR_W-1:0] s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// new_color 23:0
	output logic [rrac_pkg::COLOR_W-1:0]           m_axis_tdata,
	// covered 0
	output logic                                   m_axis_tuser
);
	import rrac_pkg::*;

	logic [COORD_W-1:0] rect_x_q;
	logic [COORD_W-1:0] rect_y_q;
	logic [DIM_W-1:0]   rect_width_q;
	logic [DIM_W-1:0]   rect_height_q;
	logic [RAD_W-1:0]   corner_radius_q;
	logic [COLOR_W-1:0] fill_color_q;
	logic [ALPHA_W-1:0] blend_alpha_q;
	logic [SQ_W-1:0]    rsq_q;

	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [COLOR_W-1:0] dest_color;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [DIM_W-1:0]   lx_s1, ly_s1;
	logic               frame_s1;
	logic [COLOR_W-1:0] dest_s1;

	logic               in_rect_s2, easy_s2;
	logic [RAD_W-1:0]   dx_s2, dy_s2;
	logic [COLOR_W-1:0] dest_s2;
	logic [PROD_W-1:0]  src_prod_s2 [NUM_CH];
	logic [PROD_W-1:0]  dst_prod_s2 [NUM_CH];

	logic               in_rect_s3, easy_s3;
	logic [SQ_W-1:0]    dxsq_s3, dysq_s3;
	logic [COLOR_W-1:0] dest_s3;
	logic [PROD_W-1:0]  mix_sum_s3 [NUM_CH];

	logic [COLOR_W-1:0] color_s4;
	logic               covered_s4;

	axis_t              ax, ay;
	logic               square;
	logic [ALPHA_W-1:0] inv_alpha;
	logic [SQ_W:0]      dist_sum;
	logic               hit;
	logic [COLOR_W-1:0] mixed;

	assign pixel_x    = s_axis_tdata[COORD_W-1:0];
	assign pixel_y    = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign dest_color = s_axis_tdata[2*COORD_W+COLOR_W-1:2*COORD_W];

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_x_q        <= '0;
			rect_y_q        <= '0;
			rect_width_q    <= '0;
			rect_height_q   <= '0;
			corner_radius_q <= '0;
			fill_color_q    <= '0;
			blend_alpha_q   <= ALPHA_MAX;
			rsq_q           <= '0;
		end else begin
			rsq_q <= SQ_W'(corner_radius_q) * SQ_W'(corner_radius_q);
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_RECT_X:      rect_x_q        <= cfg_data[COORD_W-1:0];
					REG_RECT_Y:      rect_y_q        <= cfg_data[COORD_W-1:0];
					REG_RECT_WIDTH:  rect_width_q    <= cfg_data[DIM_W-1:0];
					REG_RECT_HEIGHT: rect_height_q   <= cfg_data[DIM_W-1:0];
					REG_CORNER_RAD:  corner_radius_q <= cfg_data[RAD_W-1:0];
					REG_FILL_COLOR:  fill_color_q    <= cfg_data[COLOR_W-1:0];
					REG_BLEND_ALPHA: blend_alpha_q   <= cfg_data[ALPHA_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// stage readiness
	assign rdy_s4 = !v_s4 || m_axis_tready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_axis_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// geometry and blend terms
	always_comb begin
		ax        = axis_eval(lx_s1, rect_width_q, corner_radius_q);
		ay        = axis_eval(ly_s1, rect_height_q, corner_radius_q);
		square    = (corner_radius_q == '0)
			|| (rect_width_q < {corner_radius_q, 1'b0})
			|| (rect_height_q < {corner_radius_q, 1'b0});
		inv_alpha = ALPHA_MAX - blend_alpha_q;
		dist_sum  = {1'b0, dxsq_s3} + {1'b0, dysq_s3};
		hit       = (blend_alpha_q != '0) && in_rect_s3
			&& (easy_s3 || dist_sum <= {1'b0, rsq_q});
		for (int c = 0; c < NUM_CH; c++) begin
			mixed[c*CH_W +: CH_W] = div255(mix_sum_s3[c]);
		end
	end

	// s1: offsets from the rectangle corner
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			lx_s1    <= {1'b0, pixel_x} - {1'b0, rect_x_q};
			ly_s1    <= {1'b0, pixel_y} - {1'b0, rect_y_q};
			frame_s1 <= (32'(pixel_x) < COORD_LIMIT) && (32'(pixel_y) < COORD_LIMIT);
			dest_s1  <= dest_color;
		end
	end

	// s2: coverage class, corner distances, channel products
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			in_rect_s2 <= frame_s1 && ax.in_span && ay.in_span;
			easy_s2    <= square || ax.strip || ay.strip;
			dx_s2      <= ax.corner_off;
			dy_s2      <= ay.corner_off;
			dest_s2    <= dest_s1;
			for (int c = 0; c < NUM_CH; c++) begin
				src_prod_s2[c] <= PROD_W'(fill_color_q[c*CH_W +: CH_W])
					* PROD_W'(blend_alpha_q);
				dst_prod_s2[c] <= PROD_W'(dest_s1[c*CH_W +: CH_W]) * PROD_W'(inv_alpha);
			end
		end
	end

	// s3: squared distances, channel sums
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			in_rect_s3 <= in_rect_s2;
			easy_s3    <= easy_s2;
			dxsq_s3    <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
			dysq_s3    <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
			dest_s3    <= dest_s2;
			for (int c = 0; c < NUM_CH; c++) begin
				mix_sum_s3[c] <= src_prod_s2[c] + dst_prod_s2[c];
			end
		end
	end

	// s4: disc test and final colour
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			covered_s4 <= hit;
			color_s4   <= hit ? mixed : dest_s3;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = color_s4;
	assign m_axis_tuser  = covered_s4;

	`RRAC_ASSERT_IMPL(a_cov_needs_alpha, m_axis_tvalid && m_axis_tuser, blend_alpha_q != '0)
	`RRAC_ASSERT_NEXT(a_out_held, v_s4 && !m_axis_tready, v_s4)
	`RRAC_ASSERT_NEXT(a_s3_held, v_s3 && !rdy_s4, v_s3)
	`RRAC_ASSERT_IMPL(a_full_when_blocked, !s_axis_tready, v_s1 && v_s2 && v_s3 && v_s4)

endmodule
